>>> hw/rtl/gcbp_pkg.sv
// Shared constants for the Golomb codeword bit packer.
package gcbp_pkg;

	localparam int DEFAULT_MAX_FIELD_BITS = 32;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 8;

	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;

	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_FLUSH  = 1'b1;

endpackage

>>> hw/rtl/gcbp_front.sv
// Front end: accepts requests, clamps lengths and builds a left-aligned bit job.
module gcbp_front #(
	parameter int MAX_FIELD_BITS = gcbp_pkg::DEFAULT_MAX_FIELD_BITS,
	localparam int W  = 2 * MAX_FIELD_BITS,
	localparam int LW = $clog2(W + 1),
	localparam int JW = 1 + LW + W
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [gcbp_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             s_tuser,
	output logic                             job_valid,
	input  logic                             job_ready,
	output logic [JW-1:0]                    job_data
);
	import gcbp_pkg::*;

	localparam int CW = $clog2(MAX_FIELD_BITS + 1);

	logic [CODE_W-1:0] code_value;
	logic [LEN_W-1:0]  value_bits;
	logic [LEN_W-1:0]  unary_length;
	logic [CW-1:0]     vb;
	logic [CW-1:0]     ub;
	logic [CODE_W-1:0] mask;
	logic [CODE_W-1:0] masked;
	logic [W+CODE_W-1:0] wide;
	logic [LW-1:0]     sh_val;
	logic [LW-1:0]     sh_un;
	logic [W-1:0]      word;
	logic [LW-1:0]     len;
	logic [JW-1:0]     job;
	logic              accept;
	logic              job_valid_q;
	logic [JW-1:0]     job_data_q;

	assign code_value   = s_tdata[CODE_W-1:0];
	assign value_bits   = s_tdata[CODE_W+LEN_W-1:CODE_W];
	assign unary_length = s_tdata[CODE_W+2*LEN_W-1:CODE_W+LEN_W];

	always_comb begin
		if (32'(value_bits) > 32'(MAX_FIELD_BITS)) begin
			vb = CW'(MAX_FIELD_BITS);
		end else begin
			vb = CW'(value_bits);
		end
		if (32'(unary_length) > 32'(MAX_FIELD_BITS)) begin
			ub = CW'(MAX_FIELD_BITS);
		end else begin
			ub = CW'(unary_length);
		end
		if (32'(vb) >= 32'(CODE_W)) begin
			mask = '1;
		end else begin
			mask = (CODE_W'(1) << vb) - CODE_W'(1);
		end
		masked = code_value & mask;
		sh_val = LW'(W - 32'(vb));
		sh_un  = LW'(W - 32'(vb) - 32'(ub));
		wide   = (W + CODE_W)'(masked) << sh_val;
		word   = wide[W-1:0];
		if (ub != '0) begin
			word = word | (W'(1) << sh_un);
		end
		len = LW'(vb) + LW'(ub);
		if (s_tuser == REQ_FLUSH) begin
			job = {REQ_FLUSH, LW'(0), W'(0)};
		end else begin
			job = {REQ_APPEND, len, word};
		end
	end

	assign s_tready = !job_valid_q || job_ready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
		end else if (accept) begin
			job_valid_q <= 1'b1;
		end else if (job_ready) begin
			job_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_data_q <= job;
		end
	end

	assign job_valid = job_valid_q;
	assign job_data  = job_data_q;

endmodule

>>> hw/rtl/gcbp_queue.sv
// Two-entry job queue between the front end and the byte packer.
module gcbp_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	import gcbp_pkg::*;

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign in_ready  = count_q != 2'd2;
	assign out_valid = count_q != 2'd0;
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

>>> hw/rtl/gcbp_back.sv
// Back end: merges job bits into the pending byte and emits one byte per beat.
module gcbp_back #(
	parameter int MAX_FIELD_BITS = gcbp_pkg::DEFAULT_MAX_FIELD_BITS,
	localparam int W  = 2 * MAX_FIELD_BITS,
	localparam int LW = $clog2(W + 1),
	localparam int JW = 1 + LW + W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              job_valid,
	output logic                              job_ready,
	input  logic [JW-1:0]                     job_data,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [gcbp_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                              m_tlast
);
	import gcbp_pkg::*;

	localparam int TW = LW + 1;

	logic          busy_q;
	logic          flush_q;
	logic [W-1:0]  word_q;
	logic [LW-1:0] rem_q;
	logic [7:0]    partial_q;
	logic [2:0]    filled_q;
	logic          ov_q;
	logic [7:0]    obyte_q;
	logic          olast_q;

	logic          out_free;
	logic          step;
	logic [TW-1:0] total;
	logic [3:0]    take;
	logic [W-1:0]  shifted;
	logic [7:0]    merged;
	logic [7:0]    new_top;
	logic          emit;
	logic [7:0]    emit_byte;
	logic          emit_last;

	assign out_free  = !ov_q || m_tready;
	assign step      = busy_q && out_free;
	assign job_ready = !busy_q;

	always_comb begin
		total   = TW'(filled_q) + TW'(rem_q);
		take    = 4'd8 - {1'b0, filled_q};
		shifted = word_q << take;
		merged  = partial_q | (word_q[W-1 -: 8] >> filled_q);
		new_top = shifted[W-1 -: 8];
		if (flush_q) begin
			emit      = step && (filled_q != 3'd0);
			emit_byte = partial_q;
			emit_last = 1'b1;
		end else begin
			emit      = step && (total >= TW'(8));
			emit_byte = merged;
			emit_last = total < TW'(16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			flush_q   <= 1'b0;
			partial_q <= 8'd0;
			filled_q  <= 3'd0;
		end else if (!busy_q) begin
			if (job_valid) begin
				busy_q  <= 1'b1;
				flush_q <= job_data[JW-1];
			end
		end else if (out_free) begin
			if (flush_q) begin
				partial_q <= 8'd0;
				filled_q  <= 3'd0;
				busy_q    <= 1'b0;
			end else if (total >= TW'(16)) begin
				partial_q <= 8'd0;
				filled_q  <= 3'd0;
			end else if (total >= TW'(8)) begin
				partial_q <= new_top;
				filled_q  <= total[2:0];
				busy_q    <= 1'b0;
			end else begin
				partial_q <= merged;
				filled_q  <= total[2:0];
				busy_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			word_q <= job_data[W-1:0];
			rem_q  <= job_data[W+LW-1:W];
		end else if (out_free && !flush_q && total >= TW'(16)) begin
			word_q <= shifted;
			rem_q  <= rem_q - LW'(take);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			obyte_q <= emit_byte;
			olast_q <= emit_last;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = obyte_q;
	assign m_tlast  = olast_q;

endmodule

>>> hw/rtl/golomb_code_bit_packer.sv
// Top level of the Golomb codeword bit packer.
//
// Input stream (s_*): one beat per request. s_tuser selects append or flush.
// An append adds the low value_bits bits of code_value, most significant first,
// then unary_length-1 zeros and a one; lengths above MAX_FIELD_BITS saturate.
// A flush emits the pending partial byte padded with zeros, if it is not empty.
// Output stream (m_*): one packed byte per beat, first bit in bit 7; m_tlast
// marks the final byte caused by a request. Requests that complete no byte
// produce no beat.
// A request is registered in the front end, waits in a two-entry queue, is
// loaded into the back-end job register and leaves through the output
// register. The packer takes one step per emitted byte, at least one, at one
// byte per cycle while the output register is free, and takes no new job
// until the last job is done.
// Reset empties the queue and clears the pending byte. A stalled receiver holds
// the output register; the packer then stops, the queue and the front register
// fill, and then s_tready drops.
module golomb_code_bit_packer #(
	parameter int MAX_FIELD_BITS = gcbp_pkg::DEFAULT_MAX_FIELD_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [gcbp_pkg::IN_TDATA_W-1:0]   s_tdata,  // code_value, value_bits, unary_length
	input  logic                              s_tuser,  // req_type
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [gcbp_pkg::OUT_TDATA_W-1:0]  m_tdata,  // out_byte
	output logic                              m_tlast   // last_of_run
);
	import gcbp_pkg::*;

	localparam int W  = 2 * MAX_FIELD_BITS;
	localparam int LW = $clog2(W + 1);
	localparam int JW = 1 + LW + W;

	logic          fj_valid;
	logic          fj_ready;
	logic [JW-1:0] fj_data;
	logic          bj_valid;
	logic          bj_ready;
	logic [JW-1:0] bj_data;

	gcbp_front #(
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.job_valid (fj_valid),
		.job_ready (fj_ready),
		.job_data  (fj_data)
	);

	gcbp_queue #(
		.WIDTH(JW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fj_valid),
		.in_ready  (fj_ready),
		.in_data   (fj_data),
		.out_valid (bj_valid),
		.out_ready (bj_ready),
		.out_data  (bj_data)
	);

	gcbp_back #(
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bj_valid),
		.job_ready (bj_ready),
		.job_data  (bj_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
